### hw/rtl/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// Shared types and constants of the OOK pulse-width weather packet decoder.
// ----------------------------------------------------------------------------
package opd_pkg;

    localparam int FRAME_BITS = 44;
    localparam int CNT_W      = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_SHORT_TIME = 2'd0;
    localparam logic [1:0] CFG_LONG_TIME  = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd2;
    localparam logic [1:0] CFG_PROTOCOL   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DECODED = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // sensor type nibbles
    localparam logic [3:0] TYPE_TEMP  = 4'h0;
    localparam logic [3:0] TYPE_HUMID = 4'hE;

    typedef enum logic {
        EV_INCOMPLETE,
        EV_COMPLETE
    } ev_kind_t;

    // frame event passed from front to back
    typedef struct packed {
        ev_kind_t                kind;
        logic [FRAME_BITS-1:0]   code;
        logic [CNT_W-1:0]        length;
    } ev_t;

    // pulse matching setup handed to the front
    typedef struct packed {
        logic [15:0] short_time;
        logic [15:0] long_time;
        logic [16:0] short_tol;
        logic [16:0] long_tol;
    } tol_cfg_t;

    // one result item
    typedef struct packed {
        logic [1:0]            status;
        logic [3:0]            unit_type;
        logic [6:0]            unit_id;
        logic                  batt_weak;
        logic signed [11:0]    temperature_tenths;
        logic [7:0]            humidity_percent;
        logic                  checksum_ok;
        logic [FRAME_BITS-1:0] raw_code;
        logic [CNT_W-1:0]      bit_length;
        logic [7:0]            protocol_echo;
    } res_t;

endpackage

### hw/rtl/ook_pwm_weather_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// ook_pwm_weather_packet_decoder_unit
// Pulse-pair decoder for 44-bit OOK pulse-width weather sensor packets.
// ----------------------------------------------------------------------------
// A frame's result passes the event queue and the output register to m_tvalid.
// Throughput: one pulse pair per cycle while s_tready is high; the classifier
// is combinational. A full queue holds s_tready low, and so does each
// configuration write while the tolerance pipeline (multiply, then reciprocal
// divide by 100) settles. Reset clears frame state, the queue and the output
// valid flag, loads the register defaults and runs the same tolerance settle.
// ----------------------------------------------------------------------------
module ook_pwm_weather_packet_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // pulse pair stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // high_duration[15:0], low_duration[31:16]
    input  logic        s_tlast,   // frame_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // unit_type[3:0], unit_id[10:4], batt_weak[11],
    // temperature_tenths[23:12], humidity_percent[31:24], checksum_ok[32],
    // raw_code[76:33], bit_length[82:77], protocol_echo[90:83], zero[95:91]
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser,   // status[1:0]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // divide by 100 as (x >> 2) * ceil(2^26 / 25) >> 26, exact for x < 2^23
    localparam logic [21:0] RECIP_25 = 22'd2684355;

    // configuration registers
    logic [15:0] short_time_reg;
    logic [15:0] long_time_reg;
    logic [6:0]  tol_pct_reg;
    logic [7:0]  protocol_reg;

    // tolerance pipeline
    logic [22:0] short_prod_reg, long_prod_reg;
    logic [16:0] short_tol_reg, long_tol_reg;
    logic [42:0] short_quot, long_quot;
    logic [1:0]  settle_reg, settle_next;

    logic              cfg_fire;
    logic              in_fire;
    logic              ev_push, ev_pop, q_full, q_valid;
    opd_pkg::ev_t      ev_in, ev_out;
    opd_pkg::tol_cfg_t tol_cfg;
    opd_pkg::res_t     res;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // take no pair while tolerances settle or while the queue has no room
    assign s_tready = (settle_reg == '0) && !q_full;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        short_quot  = 43'(short_prod_reg[22:2]) * 43'(RECIP_25);
        long_quot   = 43'(long_prod_reg[22:2]) * 43'(RECIP_25);
        settle_next = settle_reg;
        if (cfg_fire)
        begin
            settle_next = 2'd2;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_time_reg <= 16'd550;
            long_time_reg  <= 16'd1100;
            tol_pct_reg    <= 7'd30;
            protocol_reg   <= 8'd0;
            settle_reg     <= 2'd2;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    opd_pkg::CFG_SHORT_TIME: short_time_reg <= cfg_data;
                    opd_pkg::CFG_LONG_TIME:  long_time_reg  <= cfg_data;
                    opd_pkg::CFG_TOLERANCE:  tol_pct_reg    <= cfg_data[6:0];
                    opd_pkg::CFG_PROTOCOL:   protocol_reg   <= cfg_data[7:0];
                endcase
            end
        end
    end

    // advance the tolerance pipeline every cycle; the settle count covers it
    always_ff @(posedge clk)
    begin
        short_prod_reg <= 23'(short_time_reg) * 23'(tol_pct_reg);
        long_prod_reg  <= 23'(long_time_reg) * 23'(tol_pct_reg);
        short_tol_reg  <= short_quot[42:26];
        long_tol_reg   <= long_quot[42:26];
    end

    assign tol_cfg.short_time = short_time_reg;
    assign tol_cfg.long_time  = long_time_reg;
    assign tol_cfg.short_tol  = short_tol_reg;
    assign tol_cfg.long_tol   = long_tol_reg;

    opd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .high_duration (s_tdata[15:0]),
        .low_duration  (s_tdata[31:16]),
        .frame_end     (s_tlast),
        .tol_cfg       (tol_cfg),
        .ev_push       (ev_push),
        .ev            (ev_in)
    );

    opd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_push),
        .push_data (ev_in),
        .full      (q_full),
        .pop       (ev_pop),
        .valid     (q_valid),
        .pop_data  (ev_out)
    );

    opd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .ev_valid        (q_valid),
        .ev              (ev_out),
        .ev_pop          (ev_pop),
        .protocol_number (protocol_reg),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res             (res)
    );

    // pack result fields, lowest first
    assign m_tuser = res.status;
    assign m_tdata = {5'd0,
                      res.protocol_echo,
                      res.bit_length,
                      res.raw_code,
                      res.checksum_ok,
                      res.humidity_percent,
                      res.temperature_tenths,
                      res.batt_weak,
                      res.unit_id,
                      res.unit_type};

endmodule

### hw/rtl/opd_front.sv
// ----------------------------------------------------------------------------
// opd_front
// Classify pulse pairs, collect bits and emit one frame event per frame.
// ----------------------------------------------------------------------------
module opd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [15:0]         high_duration,
    input  logic [15:0]         low_duration,
    input  logic                frame_end,
    input  opd_pkg::tol_cfg_t   tol_cfg,
    output logic                ev_push,
    output opd_pkg::ev_t        ev
);

    logic [opd_pkg::FRAME_BITS-1:0] shift_reg, shift_next;
    logic [opd_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           finished_reg, finished_next;

    logic                           hi_short, hi_long, lo_short, lo_long;
    logic                           is_zero, is_one;
    logic [opd_pkg::FRAME_BITS-1:0] shifted;
    logic [opd_pkg::CNT_W-1:0]      count_inc;

    function automatic logic near_enough(input logic [15:0] d, input logic [15:0] n,
                                         input logic [16:0] tol);
        logic [15:0] diff;
        diff = (d > n) ? (d - n) : (n - d);
        return ({1'b0, diff} < tol);
    endfunction

    always_comb
    begin
        hi_short  = near_enough(high_duration, tol_cfg.short_time, tol_cfg.short_tol);
        hi_long   = near_enough(high_duration, tol_cfg.long_time, tol_cfg.long_tol);
        lo_short  = near_enough(low_duration, tol_cfg.short_time, tol_cfg.short_tol);
        lo_long   = near_enough(low_duration, tol_cfg.long_time, tol_cfg.long_tol);
        is_zero   = hi_short && lo_long;
        is_one    = hi_long && lo_short;
        // a pair that fits both symbols counts as a zero
        shifted   = {shift_reg[opd_pkg::FRAME_BITS-2:0], !is_zero};
        count_inc = count_reg + 1'b1;

        shift_next    = shift_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        ev_push       = 1'b0;
        ev.kind       = opd_pkg::EV_INCOMPLETE;
        ev.code       = shift_reg;
        ev.length     = count_reg;

        if (in_fire && !finished_reg)
        begin
            if (is_zero || is_one)
            begin
                shift_next = shifted;
                count_next = count_inc;
                ev.code    = shifted;
                ev.length  = count_inc;
                if (count_inc >= opd_pkg::CNT_W'(opd_pkg::FRAME_BITS))
                begin
                    ev.kind       = opd_pkg::EV_COMPLETE;
                    ev_push       = 1'b1;
                    finished_next = 1'b1;
                end
                else if (frame_end)
                begin
                    ev_push = 1'b1;
                end
            end
            else
            begin
                // bad pulse: report bits so far, drop the rest of the frame
                ev_push       = 1'b1;
                finished_next = 1'b1;
            end
        end

        if (in_fire && frame_end)
        begin
            shift_next    = '0;
            count_next    = '0;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            count_reg    <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
        end
    end

endmodule

### hw/rtl/opd_fifo.sv
// ----------------------------------------------------------------------------
// opd_fifo
// Short event queue between front and back.
// ----------------------------------------------------------------------------
module opd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  opd_pkg::ev_t  push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output opd_pkg::ev_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    opd_pkg::ev_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/opd_back.sv
// ----------------------------------------------------------------------------
// opd_back
// Decode frame events into result items and hold them in the output register.
// ----------------------------------------------------------------------------
module opd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ev_valid,
    input  opd_pkg::ev_t  ev,
    output logic          ev_pop,
    input  logic [7:0]    protocol_number,
    output logic          res_valid,
    input  logic          res_ready,
    output opd_pkg::res_t res
);

    logic          out_valid_reg, out_valid_next;
    opd_pkg::res_t res_reg, res_next;

    logic [3:0]  nib_type, nib_h, nib_t, nib_o;
    logic [10:0] value;
    logic [23:0] hum_prod;
    logic [6:0]  nib_sum;

    assign ev_pop    = ev_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        nib_type = ev.code[39:36];
        nib_h    = ev.code[27:24];
        nib_t    = ev.code[23:20];
        nib_o    = ev.code[19:16];
        value    = 11'(nib_h) * 11'd100 + 11'(nib_t) * 11'd10 + 11'(nib_o);
        // value / 10 by reciprocal, exact for every 11-bit value
        hum_prod = 24'(value) * 24'd6554;
        nib_sum  = 7'(ev.code[39:36]) + 7'(ev.code[35:32]) + 7'(ev.code[31:28])
                 + 7'(ev.code[27:24]) + 7'(ev.code[23:20]) + 7'(ev.code[19:16])
                 + 7'(ev.code[15:12]) + 7'(ev.code[11:8]);

        res_next            = '0;
        res_next.raw_code   = ev.code;
        res_next.bit_length = ev.length;
        res_next.status     = opd_pkg::ST_BAD;

        if (ev.kind == opd_pkg::EV_COMPLETE)
        begin
            res_next.unit_type = nib_type;
            if (nib_type != opd_pkg::TYPE_TEMP && nib_type != opd_pkg::TYPE_HUMID)
            begin
                res_next.status = opd_pkg::ST_UNKNOWN;
            end
            else
            begin
                res_next.status        = opd_pkg::ST_DECODED;
                res_next.unit_id       = ev.code[35:29];
                res_next.batt_weak     = !ev.code[28];
                res_next.checksum_ok   = ({1'b0, nib_sum} == ev.code[7:0]);
                res_next.protocol_echo = protocol_number;
                if (nib_type == opd_pkg::TYPE_TEMP)
                begin
                    res_next.temperature_tenths = 12'({1'b0, value} - 12'd500);
                end
                else
                begin
                    res_next.humidity_percent = hum_prod[23:16];
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (ev_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### bench/weather_decode_checker.sv
// ----------------------------------------------------------------------------
// weather_decode_checker
// Predicts each decoder result from the accepted pulse pairs and register
// writes, and compares it field by field with the result stream.
// ----------------------------------------------------------------------------
module weather_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          packets_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]                    short_nom;
    logic [15:0]                    long_nom;
    logic [6:0]                     tol_pct;
    logic [7:0]                     proto_id;

    logic [opd_pkg::FRAME_BITS-1:0] shift_code;
    logic [opd_pkg::CNT_W-1:0]      bits_seen;
    logic                           frame_done;

    opd_pkg::res_t                  predicted_packets[$];

    // strict match: |d - nom| < nom * percent / 100, truncated
    function automatic logic pulse_fits(input logic [15:0] d, input logic [15:0] nom);
        int unsigned tol;
        int unsigned diff;
        tol  = 32'(nom);
        tol  = tol * tol_pct / 100;
        diff = 32'((d > nom) ? d - nom : nom - d);
        return diff < tol;
    endfunction

    function automatic opd_pkg::res_t packet_fields(
        input logic [opd_pkg::FRAME_BITS-1:0] c);
        opd_pkg::res_t r;
        int unsigned   val;
        int unsigned   nsum;
        int unsigned   tmp;
        r            = '0;
        r.unit_type  = c[39:36];
        r.raw_code   = c;
        r.bit_length = opd_pkg::CNT_W'(opd_pkg::FRAME_BITS);
        if (c[39:36] != opd_pkg::TYPE_TEMP && c[39:36] != opd_pkg::TYPE_HUMID)
        begin
            r.status = opd_pkg::ST_UNKNOWN;
            return r;
        end
        val  = c[27:24] * 100 + c[23:20] * 10 + c[19:16];
        nsum = 0;
        for (int k = 1; k <= 8; k++)
            nsum += c[(40 - 4 * k) +: 4];
        r.status    = opd_pkg::ST_DECODED;
        r.unit_id   = c[35:29];
        r.batt_weak = ~c[28];
        if (c[39:36] == opd_pkg::TYPE_TEMP)
        begin
            tmp                  = val - 500;
            r.temperature_tenths = tmp[11:0];
        end
        else
        begin
            tmp                = val / 10;
            r.humidity_percent = tmp[7:0];
        end
        r.checksum_ok   = (nsum[7:0] == c[7:0]);
        r.protocol_echo = proto_id;
        return r;
    endfunction

    task automatic take_pair(input logic [15:0] hi, input logic [15:0] lo, input logic last);
        opd_pkg::res_t r;
        logic          ended;
        r     = '0;
        ended = 1'b0;
        if (!frame_done)
        begin
            if (pulse_fits(hi, short_nom) && pulse_fits(lo, long_nom))
            begin
                shift_code = {shift_code[opd_pkg::FRAME_BITS-2:0], 1'b0};
                bits_seen++;
            end
            else if (pulse_fits(hi, long_nom) && pulse_fits(lo, short_nom))
            begin
                shift_code = {shift_code[opd_pkg::FRAME_BITS-2:0], 1'b1};
                bits_seen++;
            end
            else
            begin
                r.status     = opd_pkg::ST_BAD;
                r.raw_code   = shift_code;
                r.bit_length = bits_seen;
                frame_done   = 1'b1;
                ended        = 1'b1;
            end
            if (!ended)
            begin
                if (bits_seen >= opd_pkg::FRAME_BITS)
                begin
                    r          = packet_fields(shift_code);
                    frame_done = 1'b1;
                    ended      = 1'b1;
                end
                else if (last)
                begin
                    r.status     = opd_pkg::ST_BAD;
                    r.raw_code   = shift_code;
                    r.bit_length = bits_seen;
                    ended        = 1'b1;
                end
            end
            if (ended)
                predicted_packets.push_back(r);
        end
        if (last)
        begin
            shift_code = '0;
            bits_seen  = '0;
            frame_done = 1'b0;
        end
    endtask

    task automatic note_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        opd_pkg::res_t want;
        if (!rst_n)
        begin
            short_nom      = 16'd550;
            long_nom       = 16'd1100;
            tol_pct        = 7'd30;
            proto_id       = 8'd0;
            shift_code     = '0;
            bits_seen      = '0;
            frame_done     = 1'b0;
            predicted_packets.delete();
            mismatch_count = 0;
            packets_owed   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_packets.size() == 0)
                begin
                    $display("%0t ns: result expected none actual %0h status %0h",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_packets.pop_front();
                    note_field("status", 64'(want.status), 64'(m_tuser));
                    note_field("unit_type", 64'(want.unit_type), 64'(m_tdata[3:0]));
                    note_field("unit_id", 64'(want.unit_id), 64'(m_tdata[10:4]));
                    note_field("batt_weak", 64'(want.batt_weak), 64'(m_tdata[11]));
                    note_field("temperature_tenths", 64'({want.temperature_tenths}),
                               64'(m_tdata[23:12]));
                    note_field("humidity_percent", 64'(want.humidity_percent),
                               64'(m_tdata[31:24]));
                    note_field("checksum_ok", 64'(want.checksum_ok), 64'(m_tdata[32]));
                    note_field("raw_code", 64'(want.raw_code), 64'(m_tdata[76:33]));
                    note_field("bit_length", 64'(want.bit_length), 64'(m_tdata[82:77]));
                    note_field("protocol_echo", 64'(want.protocol_echo),
                               64'(m_tdata[90:83]));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    opd_pkg::CFG_SHORT_TIME: short_nom = cfg_data;
                    opd_pkg::CFG_LONG_TIME:  long_nom  = cfg_data;
                    opd_pkg::CFG_TOLERANCE:  tol_pct   = cfg_data[6:0];
                    opd_pkg::CFG_PROTOCOL:   proto_id  = cfg_data[7:0];
                endcase
            end
            if (s_tvalid && s_tready)
                take_pair(s_tdata[15:0], s_tdata[31:16], s_tlast);
            packets_owed = predicted_packets.size();
        end
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pulse pairs and register writes into the weather packet decoder,
// with bursty input and a stalling result receiver, across several timing
// setups; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // shapes of one frame of pulse pairs
    typedef enum int {
        FR_FULL,    // 44 good bits, then ignored pairs unless the last bit ends the frame
        FR_EARLY,   // frame end before 44 bits
        FR_BROKEN,  // a pair that matches neither symbol
        FR_NOISE    // a few random pairs
    } frame_kind_t;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_BLOCKY
    } rx_mode_t;

    // sensor type choice for a full frame
    localparam int PICK_TEMP    = 0;
    localparam int PICK_HUMID   = 1;
    localparam int PICK_UNKNOWN = 2;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          mismatch_count;
    int          packets_owed;

    // stimulus-side copy of the timing setup, used only to shape durations
    int          cur_short;
    int          cur_long;
    int          cur_pct;

    int          items_sent;
    int          burst_left;

    ook_pwm_weather_packet_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    weather_decode_checker decode_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .packets_owed   (packets_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop: far beyond the slowest legal run of this stimulus
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result receiver: switch at random among stall patterns, each for a random span.
    // Blocky mode holds m_tready low for stalls of random length.
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       tick;
        int       hold;
        m_tready = 1'b0;
        tick     = 0;
        hold     = 0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = int'($urandom_range(64, 300));
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                unique case (mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_tready <= (tick % 5 == 0);
                    default:
                    begin
                        if (hold > 0)
                        begin
                            m_tready <= 1'b0;
                            hold--;
                        end
                        else
                        begin
                            m_tready <= 1'b1;
                            hold = ($urandom_range(0, 1) != 0) ?
                                   int'($urandom_range(5, 20)) : 0;
                        end
                    end
                endcase
            end
        end
    end

    // Offer one pair and hold it until accepted. Bursts of random length are
    // broken by random gaps; a quarter of the bursts follow on without a gap.
    // Only pairs the block acts on advance the item count.
    task automatic send_pair(input logic [15:0] hi, input logic [15:0] lo,
                             input logic last, input bit live);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = int'($urandom_range(1, 40));
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (live)
            items_sent++;
    endtask

    // Drop the input and wait until every predicted result has come out, then
    // let the pipeline drain in case the last pair was one that made no result.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (packets_owed != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        unique case (idx)
            opd_pkg::CFG_SHORT_TIME: cur_short = int'(val);
            opd_pkg::CFG_LONG_TIME:  cur_long  = int'(val);
            opd_pkg::CFG_TOLERANCE:  cur_pct   = int'(val);
            default: ;
        endcase
    endtask

    // Reprogram the timing setup and the protocol number, only once the block is idle.
    task automatic apply_settings(input int short_t, input int long_t,
                                  input int pct, input int proto);
        wait_idle();
        write_reg(opd_pkg::CFG_SHORT_TIME, short_t[15:0]);
        write_reg(opd_pkg::CFG_LONG_TIME, long_t[15:0]);
        write_reg(opd_pkg::CFG_TOLERANCE, pct[15:0]);
        write_reg(opd_pkg::CFG_PROTOCOL, proto[15:0]);
    endtask

    // A duration inside the tolerance window, sometimes just inside its border (any if it is empty).
    function automatic logic [15:0] near_value(input int nom);
        int tol;
        int off;
        int d;
        tol = nom * cur_pct / 100;
        if (tol == 0)
            return 16'($urandom_range(0, 65535));
        off = ($urandom_range(0, 7) == 0) ? tol - 1 : int'($urandom_range(0, tol - 1));
        d   = ($urandom_range(0, 1) == 0) ? nom + off : nom - off;
        if (d > 65535)
            d = nom - off;
        return d[15:0];
    endfunction

    // A duration exactly one tolerance away: just outside the window.
    function automatic logic [15:0] off_value(input int nom);
        int d;
        d = nom + nom * cur_pct / 100;
        if (d > 65535)
            d = nom - nom * cur_pct / 100;
        return d[15:0];
    endfunction

    task automatic send_bit(input bit b, input logic last, input bit live);
        if (b)
            send_pair(near_value(cur_long), near_value(cur_short), last, live);
        else
            send_pair(near_value(cur_short), near_value(cur_long), last, live);
    endtask

    task automatic send_bad(input logic last);
        if ($urandom_range(0, 1) != 0)
            send_pair(off_value(cur_short), near_value(cur_long), last, 1'b1);
        else
            send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      last, 1'b1);
    endtask

    // Pairs after the frame's result are ignored until the frame end.
    task automatic finish_frame();
        int trail;
        trail = int'($urandom_range(0, 3));
        repeat (trail)
            send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      1'b0, 1'b0);
        send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  1'b1, 1'b0);
    endtask

    // Random packet with a chosen type, mostly with a valid checksum and half
    // the time with decimal digits in the value nibbles.
    function automatic logic [opd_pkg::FRAME_BITS-1:0] make_code(input int type_pick);
        logic [63:0]                    wide;
        logic [opd_pkg::FRAME_BITS-1:0] c;
        int unsigned                    nsum;
        wide = {$urandom, $urandom};
        c    = wide[opd_pkg::FRAME_BITS-1:0];
        unique case (type_pick)
            PICK_TEMP:    c[39:36] = opd_pkg::TYPE_TEMP;
            PICK_HUMID:   c[39:36] = opd_pkg::TYPE_HUMID;
            PICK_UNKNOWN:
            begin
                while (c[39:36] == opd_pkg::TYPE_TEMP || c[39:36] == opd_pkg::TYPE_HUMID)
                    c[39:36] = 4'($urandom_range(0, 15));
            end
            default: ;
        endcase
        if ($urandom_range(0, 1) != 0)
        begin
            c[27:24] = 4'($urandom_range(0, 9));
            c[23:20] = 4'($urandom_range(0, 9));
            c[19:16] = 4'($urandom_range(0, 9));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            nsum = 0;
            for (int k = 1; k <= 8; k++)
                nsum += c[(40 - 4 * k) +: 4];
            c[7:0] = nsum[7:0];
        end
        return c;
    endfunction

    task automatic run_frame(input frame_kind_t kind, input int type_pick);
        logic [opd_pkg::FRAME_BITS-1:0] code;
        int                             n;
        bit                             end_on_bit;
        unique case (kind)
            FR_FULL:
            begin
                code       = make_code(type_pick);
                end_on_bit = ($urandom_range(0, 3) == 0);
                for (int i = opd_pkg::FRAME_BITS - 1; i >= 0; i--)
                    send_bit(code[i], end_on_bit && i == 0, 1'b1);
                if (!end_on_bit)
                    finish_frame();
            end
            FR_EARLY:
            begin
                n = int'($urandom_range(1, opd_pkg::FRAME_BITS - 1));
                for (int i = 0; i < n; i++)
                    send_bit(1'($urandom_range(0, 1)), i == n - 1, 1'b1);
            end
            FR_BROKEN:
            begin
                n = int'($urandom_range(0, opd_pkg::FRAME_BITS - 1));
                for (int i = 0; i < n; i++)
                    send_bit(1'($urandom_range(0, 1)), 1'b0, 1'b1);
                if ($urandom_range(0, 3) == 0)
                begin
                    send_bad(1'b1);
                end
                else
                begin
                    send_bad(1'b0);
                    finish_frame();
                end
            end
            default:
            begin
                n = int'($urandom_range(1, 6));
                for (int i = 0; i < n; i++)
                    send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              i == n - 1, 1'b1);
            end
        endcase
    endtask

    initial
    begin
        int          quota;
        int          r;
        int          s_nom;
        frame_kind_t kind;

        // hold every input at a known value through reset
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = opd_pkg::CFG_SHORT_TIME;
        cfg_data   = '0;
        cur_short  = 550;
        cur_long   = 1100;
        cur_pct    = 30;
        items_sent = 0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pairs on the reset setup (550 / 1100 ticks, 30 percent,
        // so windows of 165 and 330 ticks). Extremes of the durations first.
        send_pair(16'd0, 16'd0, 1'b1, 1'b1);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_pair(16'hFFFF, 16'd0, 1'b1, 1'b1);
        send_pair(16'd0, 16'hFFFF, 1'b1, 1'b1);
        // both symbols, one pair just inside each window border, early end
        send_pair(16'd550, 16'd1100, 1'b0, 1'b1);
        send_pair(16'd1100, 16'd550, 1'b0, 1'b1);
        send_pair(16'd714, 16'd771, 1'b0, 1'b1);
        send_pair(16'd1429, 16'd386, 1'b1, 1'b1);
        // high exactly at the border: bad pulse, then ignored pairs to the end
        send_pair(16'd550, 16'd1100, 1'b0, 1'b1);
        send_pair(16'd715, 16'd1100, 1'b0, 1'b1);
        send_pair(16'd550, 16'd1100, 1'b0, 1'b0);
        send_pair(16'd0, 16'd0, 1'b1, 1'b0);
        // single-bit frame ended at once
        send_pair(16'd1100, 16'd550, 1'b1, 1'b1);
        // low exactly at the border of the long window
        send_pair(16'd386, 16'd1100, 1'b0, 1'b1);
        send_pair(16'd550, 16'd770, 1'b0, 1'b1);
        send_pair(16'd0, 16'd0, 1'b1, 1'b0);
        // bad pulse on the frame end pair
        send_pair(16'd1, 16'd1, 1'b1, 1'b1);
        // one packet of each type
        run_frame(FR_FULL, PICK_TEMP);
        run_frame(FR_FULL, PICK_HUMID);
        run_frame(FR_FULL, PICK_UNKNOWN);

        // Random phases; each but phase 0 writes a setup first. The block is drained
        // before every change, so the sender pauses until all results are out.
        for (int phase = 0; phase < 9; phase++)
        begin
            unique case (phase)
                1: apply_settings(1000, 3000, 100, 255);
                2: apply_settings(65535, 32768, 10, 90);
                3: apply_settings(0, 65535, 0, 1);    // nothing can match
                4: apply_settings(300, 900, 50, 165);
                5, 6, 7:
                begin
                    s_nom = int'($urandom_range(50, 15000));
                    apply_settings(s_nom, s_nom * int'($urandom_range(2, 4)),
                                   int'($urandom_range(5, 45)),
                                   int'($urandom_range(0, 255)));
                end
                8: apply_settings(550, 1100, 30, 0);
                default: ;
            endcase
            quota = items_sent + ((phase == 3) ? 30 : 110);
            while (items_sent < quota)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 60)
                    kind = FR_FULL;
                else if (r < 75)
                    kind = FR_EARLY;
                else if (r < 90)
                    kind = FR_BROKEN;
                else
                    kind = FR_NOISE;
                run_frame(kind, int'($urandom_range(PICK_TEMP, PICK_UNKNOWN + 1)));
            end
        end

        // drain, let the output settle, then give the verdict
        wait_idle();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0 && packets_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
hw/rtl/opd_pkg.sv
hw/rtl/opd_front.sv
hw/rtl/opd_fifo.sv
hw/rtl/opd_back.sv
hw/rtl/ook_pwm_weather_packet_decoder_unit.sv
bench/weather_decode_checker.sv
bench/testbench.sv
